>>> rtl/core/mfh_pkg.sv
// shared types and constants for the mqtt fixed-header framer
// used by mfh_step and mqtt_fixed_header_framer; no dependencies
package mfh_pkg;

  // widths of the frame fields
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 28;
  localparam int SEEN_W    = 3;
  localparam int TIMEOUT_W = 16;

  // length bytes allowed before the field counts as too long
  localparam int MAX_LENGTH_BYTES = 4;

  // timeout register value after reset, in milliseconds
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd3000;

  // request codes on the input channel
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_LEN,
    PH_BODY
  } phase_t;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_HEADER,
    KIND_LEN,
    KIND_BODY
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_LEN_ERR,
    ST_TIMEOUT
  } status_t;

  // framer state carried from one transfer to the next
  typedef struct packed {
    phase_t                phase;
    logic [BYTE_W-1:0]     header;
    logic [LEN_W-1:0]      accum;
    logic [SEEN_W-1:0]     seen;
    logic [LEN_W-1:0]      body_left;
    logic [TIMEOUT_W-1:0]  elapsed;
  } frm_state_t;

  // one result item
  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    kind_t              kind;
    logic               last;
    logic [BYTE_W-1:0]  header;
    logic [LEN_W-1:0]   len;
    status_t            status;
  } frm_result_t;

endpackage

>>> rtl/core/mfh_step.sv
// next-state and result logic of the framer for one input transfer
// depends on mfh_pkg
module mfh_step
  import mfh_pkg::*;
(
  input  frm_state_t            cur,
  input  logic                  req_type,
  input  logic [BYTE_W-1:0]     data_byte,
  input  logic [TIMEOUT_W-1:0]  timeout_ms,
  output frm_state_t            nxt,
  output frm_result_t           res,
  output logic                  res_valid
);

  logic [TIMEOUT_W-1:0] limit;
  logic [TIMEOUT_W-1:0] elapsed_inc;
  logic [LEN_W-1:0]     len_group;
  logic [LEN_W-1:0]     accum_new;
  logic [SEEN_W-1:0]    seen_new;
  logic [LEN_W-1:0]     body_dec;

  // zero timeout behaves like one
  assign limit = (timeout_ms == '0) ? TIMEOUT_W'(1) : timeout_ms;

  // saturating millisecond count
  assign elapsed_inc = (cur.elapsed != '1) ? cur.elapsed + TIMEOUT_W'(1) : cur.elapsed;

  // place the 7-bit length group by its position
  always_comb begin
    case (cur.seen[1:0])
      2'd0:    len_group = LEN_W'(data_byte[6:0]);
      2'd1:    len_group = LEN_W'(data_byte[6:0]) << 7;
      2'd2:    len_group = LEN_W'(data_byte[6:0]) << 14;
      default: len_group = LEN_W'(data_byte[6:0]) << 21;
    endcase
  end

  assign accum_new = cur.accum + len_group;
  assign seen_new  = cur.seen + SEEN_W'(1);
  assign body_dec  = (cur.body_left != '0) ? cur.body_left - LEN_W'(1) : cur.body_left;

  // per-transfer decision
  always_comb begin
    nxt        = cur;
    res.data   = data_byte;
    res.kind   = KIND_NONE;
    res.last   = 1'b0;
    res.header = cur.header;
    res.len    = cur.accum;
    res.status = ST_OK;
    res_valid  = 1'b0;

    if (req_type == REQ_TICK) begin
      // tick ages an open frame, idle ticks do nothing
      if (cur.phase != PH_IDLE) begin
        nxt.elapsed = elapsed_inc;
        if (elapsed_inc >= limit) begin
          res_valid     = 1'b1;
          res.data      = '0;
          res.status    = ST_TIMEOUT;
          nxt.phase     = PH_IDLE;
          nxt.elapsed   = '0;
          nxt.body_left = '0;
        end
      end
    end else begin
      res_valid = 1'b1;
      case (cur.phase)
        PH_IDLE: begin
          nxt.phase     = PH_LEN;
          nxt.header    = data_byte;
          nxt.accum     = '0;
          nxt.seen      = '0;
          nxt.body_left = '0;
          nxt.elapsed   = '0;
          res.kind      = KIND_HEADER;
          res.header    = data_byte;
          res.len       = '0;
        end
        PH_LEN: begin
          nxt.accum = accum_new;
          nxt.seen  = seen_new;
          res.kind  = KIND_LEN;
          res.len   = accum_new;
          if (!data_byte[7]) begin
            if (accum_new == '0) begin
              // zero-length frame ends on its last length byte
              nxt.phase   = PH_IDLE;
              nxt.elapsed = '0;
              res.last    = 1'b1;
            end else begin
              nxt.body_left = accum_new;
              nxt.phase     = PH_BODY;
            end
          end else if (seen_new >= SEEN_W'(MAX_LENGTH_BYTES)) begin
            // continuation past the last allowed length byte
            res.status  = ST_LEN_ERR;
            nxt.phase   = PH_IDLE;
            nxt.elapsed = '0;
          end
        end
        PH_BODY: begin
          nxt.body_left = body_dec;
          res.kind      = KIND_BODY;
          if (body_dec == '0) begin
            nxt.phase   = PH_IDLE;
            nxt.elapsed = '0;
            res.last    = 1'b1;
          end
        end
        default: begin
          res_valid = 1'b0;
          nxt.phase = PH_IDLE;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/mqtt_fixed_header_framer.sv
// top level of the mqtt fixed-header framer
// depends on mfh_pkg and mfh_step
//
// usage:
//   input channel (in_valid/in_ready) carries req_type and data_byte: a received
//   byte or a one millisecond tick. every byte gives one result on the output
//   channel (out_valid/out_ready), tagged header, length or body, with
//   frame_last on the byte that completes a frame. a tick gives a result only
//   when it times out an open frame (byte_kind none, status timeout).
//   a fourth length byte that still announces another answers with status
//   length error and drops the frame.
//   the configuration channel (cfg_valid/cfg_ready/cfg_data) writes the
//   timeout in milliseconds; write it only while the block is idle.
// registering and throughput:
//   a result is registered and appears in the cycle after its input transfer.
//   one transfer per cycle is sustained while out_ready stays high, set by the
//   single register stage of frame state and the output register.
// reset and stall:
//   rst (synchronous) returns to idle with the timeout at 3000 ms and no
//   result pending. while a result waits on out_ready, a new input is taken
//   only in the cycle that the waiting result is transferred.
module mqtt_fixed_header_framer
  import mfh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [TIMEOUT_W-1:0]  cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  req_type,
  input  logic [BYTE_W-1:0]     data_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     byte_out,
  output logic [1:0]            byte_kind,
  output logic                  frame_last,
  output logic [3:0]            packet_type,
  output logic [3:0]            header_flags,
  output logic [LEN_W-1:0]      remaining_length,
  output logic [1:0]            status
);

  logic [TIMEOUT_W-1:0] timeout_ms;
  frm_state_t           state;
  frm_state_t           state_next;
  frm_result_t          result;
  frm_result_t          result_next;
  logic                 result_next_valid;
  logic                 in_xfer;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;

  // timeout register
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ms <= cfg_data;
    end
  end

  mfh_step u_step (
    .cur        (state),
    .req_type   (req_type),
    .data_byte  (data_byte),
    .timeout_ms (timeout_ms),
    .nxt        (state_next),
    .res        (result_next),
    .res_valid  (result_next_valid)
  );

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_IDLE, default: '0};
    end else if (in_xfer) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && result_next_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && result_next_valid) begin
      result <= result_next;
    end
  end

  assign byte_out         = result.data;
  assign byte_kind        = result.kind;
  assign frame_last       = result.last;
  assign packet_type      = result.header[7:4];
  assign header_flags     = result.header[3:0];
  assign remaining_length = result.len;
  assign status           = result.status;

  // idle frame has no running timer
  a_idle_timer_clear : assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_IDLE |-> state.elapsed == '0)
    else $error("idle frame with nonzero elapsed time");

  // body phase always has bytes left
  a_body_left : assert property (@(posedge clk) disable iff (rst)
    state.phase == PH_BODY |-> state.body_left != '0)
    else $error("body phase with no bytes left");

  // a result without a byte is only a timeout
  a_none_is_timeout : assert property (@(posedge clk) disable iff (rst)
    out_valid && result.kind == KIND_NONE |-> result.status == ST_TIMEOUT)
    else $error("byteless result without timeout status");

  // frame end only on a clean length or body byte
  a_last_kind : assert property (@(posedge clk) disable iff (rst)
    out_valid && result.last |->
      result.status == ST_OK && (result.kind == KIND_LEN || result.kind == KIND_BODY))
    else $error("frame end on wrong byte kind or status");

  // length error only on a length byte, and the frame is closed
  a_len_err : assert property (@(posedge clk) disable iff (rst)
    in_xfer && result_next_valid && result_next.status == ST_LEN_ERR |=>
      state.phase == PH_IDLE && result.kind == KIND_LEN)
    else $error("length error not on a length byte or frame left open");

endmodule

>>> sim/testbench.sv
// self-checking testbench for mqtt_fixed_header_framer: bytes and ticks in, tagged bytes out
// depends on mfh_pkg and the framer rtl; predicts every tag and compares it field by field
module testbench;
  import mfh_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int CYCLE_LIMIT   = 2000000;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [TIMEOUT_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic req_type;
  logic [BYTE_W-1:0] data_byte;
  logic out_valid;
  logic out_ready;
  logic [BYTE_W-1:0] byte_out;
  logic [1:0] byte_kind;
  logic frame_last;
  logic [3:0] packet_type;
  logic [3:0] header_flags;
  logic [LEN_W-1:0] remaining_length;
  logic [1:0] status;

  // shared flags between the stimulus and the receiver
  logic hold_req = 1'b0;
  logic recv_idle = 1'b1;
  bit send_idle = 1'b1;
  int tick_odds = 15;
  int mismatches = 0;
  int cycle_count = 0;

  // expected tags in transfer order
  frm_result_t tags_due[$];

  // frame tracker state, mirrors the framer
  phase_t fr_phase;
  logic [BYTE_W-1:0] fr_header;
  logic [LEN_W-1:0] fr_len;
  logic [SEEN_W-1:0] fr_seen;
  logic [LEN_W-1:0] fr_body_left;
  logic [TIMEOUT_W-1:0] fr_elapsed;
  logic [TIMEOUT_W-1:0] fr_timeout;

  mqtt_fixed_header_framer dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .byte_out(byte_out),
    .byte_kind(byte_kind),
    .frame_last(frame_last),
    .packet_type(packet_type),
    .header_flags(header_flags),
    .remaining_length(remaining_length),
    .status(status)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // works out the tag of one accepted transfer and queues it
  task automatic frame_tracker_step(input logic rq, input logic [BYTE_W-1:0] b);
    frm_result_t tag;
    logic [TIMEOUT_W-1:0] limit_ms;
    logic [LEN_W-1:0] group;
    tag = '0;
    tag.data = b;
    if (rq == REQ_TICK) begin
      // zero timeout behaves as one
      limit_ms = (fr_timeout == '0) ? TIMEOUT_W'(1) : fr_timeout;
      if (fr_phase == PH_IDLE) return;
      if (fr_elapsed != '1) fr_elapsed++;
      if (fr_elapsed < limit_ms) return;
      tag.data = '0;
      tag.kind = KIND_NONE;
      tag.status = ST_TIMEOUT;
      fr_phase = PH_IDLE;
      fr_elapsed = '0;
      fr_body_left = '0;
    end else if (fr_phase == PH_IDLE) begin
      fr_header = b;
      fr_len = '0;
      fr_seen = '0;
      fr_body_left = '0;
      fr_elapsed = '0;
      fr_phase = PH_LEN;
      tag.kind = KIND_HEADER;
    end else if (fr_phase == PH_LEN) begin
      // 7 bits per length byte, low group first
      group = LEN_W'(b[6:0]) << (7 * fr_seen[1:0]);
      fr_len = fr_len + group;
      fr_seen++;
      tag.kind = KIND_LEN;
      if (!b[7]) begin
        if (fr_len == '0) begin
          fr_phase = PH_IDLE;
          fr_elapsed = '0;
          tag.last = 1'b1;
        end else begin
          fr_body_left = fr_len;
          fr_phase = PH_BODY;
        end
      end else if (fr_seen >= MAX_LENGTH_BYTES) begin
        // one length byte too many drops the frame
        tag.status = ST_LEN_ERR;
        fr_phase = PH_IDLE;
        fr_elapsed = '0;
      end
    end else begin
      tag.kind = KIND_BODY;
      if (fr_body_left != '0) fr_body_left--;
      if (fr_body_left == '0) begin
        fr_phase = PH_IDLE;
        fr_elapsed = '0;
        tag.last = 1'b1;
      end
    end
    tag.header = fr_header;
    tag.len = fr_len;
    tags_due.push_back(tag);
  endtask

  task automatic check_field(input string fname, input logic [LEN_W-1:0] want,
                             input logic [LEN_W-1:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // compare each output transfer with the oldest expected tag
  always @(posedge clk) begin : result_check
    frm_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (tags_due.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual byte %0h kind %0d status %0d",
                 $time, byte_out, byte_kind, status);
        mismatches++;
      end else begin
        want = tags_due.pop_front();
        check_field("byte_out", LEN_W'(want.data), LEN_W'(byte_out));
        check_field("byte_kind", LEN_W'(want.kind), LEN_W'(byte_kind));
        check_field("frame_last", LEN_W'(want.last), LEN_W'(frame_last));
        check_field("packet_type", LEN_W'(want.header[7:4]), LEN_W'(packet_type));
        check_field("header_flags", LEN_W'(want.header[3:0]), LEN_W'(header_flags));
        check_field("remaining_length", want.len, remaining_length);
        check_field("status", LEN_W'(want.status), LEN_W'(status));
      end
    end
  end

  // receiver: random stall bursts and a long hold-off on request
  initial begin : receiver
    int run_left;
    int hold_left;
    bit stalled;
    run_left = 0;
    hold_left = 0;
    stalled = 1'b0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          stalled = ($urandom_range(0, 2) == 0);
          run_left = stalled ? $urandom_range(1, 13) : $urandom_range(1, 30);
        end
        run_left--;
        out_ready <= !(stalled && recv_idle);
      end
    end
  end

  // one input transfer, with an optional gap before it
  task automatic send_item(input logic rq, input logic [BYTE_W-1:0] b);
    if (send_idle && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= rq;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    frame_tracker_step(rq, b);
  endtask

  // a received byte, sometimes preceded by a tick
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(0, tick_odds) == 0) send_item(REQ_TICK, BYTE_W'($urandom_range(0, 255)));
    send_item(REQ_BYTE, b);
  endtask

  // tick until the open frame times out
  task automatic close_open_frame();
    while (fr_phase != PH_IDLE) send_item(REQ_TICK, BYTE_W'($urandom_range(0, 255)));
  endtask

  // stop sending and wait for every expected tag
  task automatic settle();
    in_valid <= 1'b0;
    while (tags_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timeout(input logic [TIMEOUT_W-1:0] ms);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= ms;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    fr_timeout = ms;
  endtask

  task automatic set_idling(input bit on);
    send_idle = on;
    recv_idle <= on;
  endtask

  // one frame with random content; mostly well formed
  task automatic send_random_frame(output int n_sent);
    logic [BYTE_W-1:0] len_enc [4];
    logic [LEN_W-1:0] rest;
    int pick, size_pick, n_len, body_len, pad, cut, i;
    bit short_timeout;
    short_timeout = (fr_timeout <= 100);
    n_sent = 0;
    if (short_timeout) close_open_frame();
    pick = $urandom_range(0, 99);
    // noise with no frame structure
    if (pick < 6 && short_timeout) begin
      repeat ($urandom_range(1, 6)) begin
        send_byte(BYTE_W'($urandom_range(0, 255)));
        n_sent++;
      end
      return;
    end
    send_byte(BYTE_W'($urandom_range(0, 255)));
    n_sent++;
    // length field that never ends
    if (pick < 12) begin
      repeat (MAX_LENGTH_BYTES) begin
        send_byte(BYTE_W'(8'h80 | $urandom_range(0, 127)));
        n_sent++;
      end
      return;
    end
    size_pick = $urandom_range(0, 99);
    if (size_pick < 20) body_len = $urandom_range(0, 3);
    else if (size_pick < 75) body_len = $urandom_range(4, 20);
    else if (size_pick < 95) body_len = $urandom_range(21, 127);
    else body_len = $urandom_range(128, 200);
    // encode the length, sometimes padded with empty groups
    rest = LEN_W'(body_len);
    n_len = 0;
    do begin
      len_enc[n_len] = {1'b0, rest[6:0]};
      rest = rest >> 7;
      if (rest != '0) len_enc[n_len][7] = 1'b1;
      n_len++;
    end while (rest != '0);
    pad = ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_LENGTH_BYTES - n_len) : 0;
    repeat (pad) begin
      len_enc[n_len-1][7] = 1'b1;
      len_enc[n_len] = 8'h00;
      n_len++;
    end
    for (i = 0; i < n_len; i++) begin
      send_byte(len_enc[i]);
      n_sent++;
    end
    // some frames stop short and are left to time out
    cut = body_len;
    if (pick < 20 && short_timeout && body_len > 0) cut = $urandom_range(0, body_len - 1);
    for (i = 0; i < cut; i++) begin
      send_byte(BYTE_W'($urandom_range(0, 255)));
      n_sent++;
    end
    if (cut < body_len) close_open_frame();
  endtask

  // reset timeout is long: ticks well short of it leave the frame open
  task automatic test_reset_timeout();
    send_item(REQ_TICK, 8'hFF);
    send_item(REQ_BYTE, 8'h3F);
    repeat (20) send_item(REQ_TICK, 8'h00);
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_BYTE, 8'h00);
    repeat (20) send_item(REQ_TICK, 8'hFF);
    send_item(REQ_BYTE, 8'h00);
  endtask

  // zero length, byte extremes, padded length, too long length, largest length
  task automatic test_directed_frames();
    logic [BYTE_W-1:0] seq [28] = '{
      8'h30, 8'h00,
      8'hFF, 8'h02, 8'h00, 8'hFF,
      8'h82, 8'h80, 8'h80, 8'h80, 8'h00,
      8'h10, 8'h81, 8'h00, 8'hA5,
      8'hC0, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
      8'hE0, 8'h00,
      8'h35, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h55
    };
    set_timeout(16'd10);
    foreach (seq[i]) send_item(REQ_BYTE, seq[i]);
    close_open_frame();
  endtask

  // timeout register extremes and a zero write
  task automatic test_timeout_extremes();
    set_timeout(16'd0);
    send_item(REQ_BYTE, 8'h20);
    send_item(REQ_TICK, 8'h00);
    set_timeout(16'd1);
    send_item(REQ_BYTE, 8'h31);
    send_item(REQ_BYTE, 8'h05);
    send_item(REQ_BYTE, 8'h11);
    send_item(REQ_TICK, 8'hFF);
    // length bytes do not restart the count
    set_timeout(16'd2);
    send_item(REQ_BYTE, 8'h00);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_BYTE, 8'h81);
    send_item(REQ_TICK, 8'h00);
    // largest timeout keeps the frame open
    set_idling(1'b0);
    set_timeout(16'hFFFF);
    send_item(REQ_BYTE, 8'h90);
    repeat (30) send_item(REQ_TICK, 8'h00);
    send_item(REQ_BYTE, 8'h00);
    set_idling(1'b1);
  endtask

  // receiver holds off while a long frame keeps coming
  task automatic test_backpressure();
    set_timeout(16'd500);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    send_item(REQ_BYTE, 8'h32);
    send_item(REQ_BYTE, 8'd40);
    repeat (40) send_item(REQ_BYTE, BYTE_W'($urandom_range(0, 255)));
    settle();
  endtask

  // random frames over several timeout settings
  task automatic test_random_traffic();
    int sent, n, ph;
    for (ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_timeout(16'd1);
        3: set_timeout(16'hFFFF);
        default: set_timeout(TIMEOUT_W'($urandom_range(2, 60)));
      endcase
      tick_odds = (ph == 3) ? 8 : $urandom_range(4, 30);
      sent = 0;
      while (sent < 150) begin
        send_random_frame(n);
        sent += n;
      end
      if (fr_timeout <= 100) close_open_frame();
    end
  endtask

  // steady traffic with no idling on either side
  task automatic test_steady_tail();
    int sent, n;
    set_idling(1'b0);
    set_timeout(16'd20);
    tick_odds = 10;
    sent = 0;
    while (sent < 150) begin
      send_random_frame(n);
      sent += n;
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    req_type <= REQ_BYTE;
    data_byte <= '0;
    fr_phase = PH_IDLE;
    fr_header = '0;
    fr_len = '0;
    fr_seen = '0;
    fr_body_left = '0;
    fr_elapsed = '0;
    fr_timeout = TIMEOUT_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_reset_timeout();
    test_directed_frames();
    test_timeout_extremes();
    test_backpressure();
    test_random_traffic();
    test_steady_tail();
    settle();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/mfh_pkg.sv
rtl/core/mfh_step.sv
rtl/core/mqtt_fixed_header_framer.sv
sim/testbench.sv
